// ===== rtl/bsac_pkg.sv =====
// ----------------------------------------------------------------------------
// bsac_pkg
// Shared types and constants for the barometric sample averaging and
// compensation block.
// ----------------------------------------------------------------------------
`default_nettype none

package bsac_pkg;

	// averaging
	localparam int AVG_SHIFT_DEF = 4;

	// field widths
	localparam int SAMPLE_W = 24;
	localparam int COEF_W   = 16;
	localparam int PRESS_W  = 23;
	localparam int TEMP_W   = 19;

	// configuration port
	localparam int NUM_COEF  = 6;
	localparam int CFG_IDX_W = 3;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_SENS        = 3'd0,
		REG_OFFSET      = 3'd1,
		REG_SENS_TEMPCO = 3'd2,
		REG_OFF_TEMPCO  = 3'd3,
		REG_REF_TEMP    = 3'd4,
		REG_TEMP_SENS   = 3'd5
	} cfg_reg_t;

	// sample kinds
	localparam logic CMD_TEMP  = 1'b0;
	localparam logic CMD_PRESS = 1'b1;

	// result limits
	localparam int P_MAX        = 4194303;
	localparam int P_MIN        = -4194304;
	localparam int T_MAX        = 262143;
	localparam int T_MIN        = -262144;
	localparam int T_OFFSET     = 2000;
	localparam int IN_RANGE_MIN = 3276800;   // 100 * 2^15

	// shared multiplier operand selection
	typedef enum logic [2:0] {
		MUL_NONE,
		MUL_TEMP,
		MUL_OFF,
		MUL_SENS,
		MUL_LO,
		MUL_HI
	} mul_sel_t;

	// controller states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DT,
		ST_MUL_T,
		ST_MUL_OFF,
		ST_MUL_SENS,
		ST_SENS,
		ST_MUL_LO,
		ST_MUL_HI,
		ST_ACC,
		ST_X,
		ST_OUT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic     avg_upd;
		logic     dt_ld;
		mul_sel_t mul_sel;
		logic     temp_ld;
		logic     off_ld;
		logic     sens_ld;
		logic     acc_ld;
		logic     acc_add;
		logic     x_ld;
		logic     out_ld;
	} cmd_t;

endpackage

`default_nettype wire

// ===== rtl/bsac_if.sv =====
// ----------------------------------------------------------------------------
// bsac_if
// Valid/ready channels for raw samples in and compensated results out.
// ----------------------------------------------------------------------------
`default_nettype none

interface bsac_in_if;
	logic                              valid;
	logic                              ready;
	logic                              cmd;
	logic [bsac_pkg::SAMPLE_W-1:0]     sample;

	modport source (output valid, output cmd, output sample, input ready);
	modport sink   (input valid, input cmd, input sample, output ready);
endinterface

interface bsac_out_if;
	logic                              valid;
	logic                              ready;
	logic signed [bsac_pkg::PRESS_W-1:0] pressure;
	logic signed [bsac_pkg::TEMP_W-1:0]  temperature;
	logic                              in_range;

	modport source (output valid, output pressure, output temperature, output in_range,
		input ready);
	modport sink   (input valid, input pressure, input temperature, input in_range,
		output ready);
endinterface

`default_nettype wire

// ===== rtl/bsac_datapath.sv =====
// ----------------------------------------------------------------------------
// bsac_datapath
// Sample averages, coefficient registers, shared multiplier and the
// compensation arithmetic, stepped by the controller.
// ----------------------------------------------------------------------------
`default_nettype none

module bsac_datapath #(
	parameter int AVG_SHIFT = bsac_pkg::AVG_SHIFT_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  bsac_pkg::cmd_t                       cmd,
	input  logic                                 in_cmd,
	input  logic [bsac_pkg::SAMPLE_W-1:0]        in_sample,
	input  logic                                 cfg_we,
	input  logic [bsac_pkg::CFG_IDX_W-1:0]       cfg_idx,
	input  logic [bsac_pkg::COEF_W-1:0]          cfg_wdata,
	output logic signed [bsac_pkg::PRESS_W-1:0]  pressure,
	output logic signed [bsac_pkg::TEMP_W-1:0]   temperature,
	output logic                                 in_range
);

	localparam int SW = bsac_pkg::SAMPLE_W;
	localparam logic signed [SW:0] DIFF_RND = (SW+1)'((1 << AVG_SHIFT) - 1);

	// coefficient registers
	logic [bsac_pkg::COEF_W-1:0] c_sens_q, c_off_q, c_sens_tc_q, c_off_tc_q;
	logic [bsac_pkg::COEF_W-1:0] c_ref_q, c_tsens_q;

	// averages and intermediate results
	logic [SW-1:0]        avg_temp_q, avg_press_q;
	logic signed [SW:0]   dt_q;
	logic signed [43:0]   prod_q;
	logic signed [21:0]   temp_sum_q;
	logic signed [35:0]   off_q, sens_q;
	logic signed [61:0]   acc_q;
	logic signed [41:0]   x_q;

	// combinational helpers
	logic [SW-1:0]        avg_cur, avg_new;
	logic signed [SW:0]   diff, diff_div;
	logic signed [SW:0]   mul_a;
	logic signed [18:0]   mul_b;
	logic signed [43:0]   t_sh, off_div, sens_div;
	logic signed [61:0]   acc_div;
	logic signed [41:0]   p_div;
	logic signed [26:0]   p_trunc;

	// configuration writes; indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			c_sens_q    <= '0;
			c_off_q     <= '0;
			c_sens_tc_q <= '0;
			c_off_tc_q  <= '0;
			c_ref_q     <= '0;
			c_tsens_q   <= '0;
		end else if (cfg_we) begin
			case (cfg_idx)
				bsac_pkg::REG_SENS:        c_sens_q    <= cfg_wdata;
				bsac_pkg::REG_OFFSET:      c_off_q     <= cfg_wdata;
				bsac_pkg::REG_SENS_TEMPCO: c_sens_tc_q <= cfg_wdata;
				bsac_pkg::REG_OFF_TEMPCO:  c_off_tc_q  <= cfg_wdata;
				bsac_pkg::REG_REF_TEMP:    c_ref_q     <= cfg_wdata;
				bsac_pkg::REG_TEMP_SENS:   c_tsens_q   <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// running average: empty average loads the sample, else step by diff/2^N
	always_comb begin
		avg_cur  = (in_cmd == bsac_pkg::CMD_PRESS) ? avg_press_q : avg_temp_q;
		diff     = $signed({1'b0, in_sample}) - $signed({1'b0, avg_cur});
		diff_div = $signed(diff + (diff[SW] ? DIFF_RND : '0)) >>> AVG_SHIFT;
		avg_new  = (avg_cur == '0) ? in_sample : avg_cur + diff_div[SW-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			avg_temp_q  <= '0;
			avg_press_q <= '0;
		end else if (cmd.avg_upd) begin
			if (in_cmd == bsac_pkg::CMD_PRESS)
				avg_press_q <= avg_new;
			else
				avg_temp_q <= avg_new;
		end
	end

	// shared multiplier operands
	always_comb begin
		unique case (cmd.mul_sel)
			bsac_pkg::MUL_TEMP: begin
				mul_a = dt_q;
				mul_b = $signed({3'b000, c_tsens_q});
			end
			bsac_pkg::MUL_OFF: begin
				mul_a = dt_q;
				mul_b = $signed({3'b000, c_off_tc_q});
			end
			bsac_pkg::MUL_SENS: begin
				mul_a = dt_q;
				mul_b = $signed({3'b000, c_sens_tc_q});
			end
			bsac_pkg::MUL_LO: begin
				mul_a = $signed({1'b0, avg_press_q});
				mul_b = $signed({1'b0, sens_q[17:0]});
			end
			bsac_pkg::MUL_HI: begin
				mul_a = $signed({1'b0, avg_press_q});
				mul_b = $signed({sens_q[35], sens_q[35:18]});
			end
			default: begin
				mul_a = '0;
				mul_b = '0;
			end
		endcase
	end

	// truncating and flooring shifts of the product and accumulator
	always_comb begin
		t_sh     = prod_q >>> 23;
		off_div  = (prod_q + (prod_q[43] ? 44'sd63 : 44'sd0)) >>> 6;
		sens_div = (prod_q + (prod_q[43] ? 44'sd127 : 44'sd0)) >>> 7;
		acc_div  = (acc_q + (acc_q[61] ? 62'sd2097151 : 62'sd0)) >>> 21;
		p_div    = (x_q + (x_q[41] ? 42'sd32767 : 42'sd0)) >>> 15;
		p_trunc  = $signed(p_div[26:0]);
	end

	// datapath registers
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (cmd.dt_ld)
			dt_q <= $signed({1'b0, avg_temp_q}) - $signed({1'b0, c_ref_q, 8'h00});
		if (cmd.temp_ld)
			temp_sum_q <= $signed(t_sh[21:0]) + 22'(bsac_pkg::T_OFFSET);
		if (cmd.off_ld)
			off_q <= $signed({3'b000, c_off_q, 17'b0}) + $signed(off_div[35:0]);
		if (cmd.sens_ld)
			sens_q <= $signed({4'b0000, c_sens_q, 16'b0}) + $signed(sens_div[35:0]);
		if (cmd.acc_ld)
			acc_q <= {{18{prod_q[43]}}, prod_q};
		else if (cmd.acc_add)
			acc_q <= acc_q + $signed({prod_q, 18'b0});
		if (cmd.x_ld)
			x_q <= $signed(acc_div[41:0]) - {{6{off_q[35]}}, off_q};
	end

	// result register with saturation
	always_ff @(posedge clk) begin
		if (cmd.out_ld) begin
			if (p_trunc > bsac_pkg::P_MAX)
				pressure <= bsac_pkg::PRESS_W'(bsac_pkg::P_MAX);
			else if (p_trunc < bsac_pkg::P_MIN)
				pressure <= bsac_pkg::PRESS_W'(bsac_pkg::P_MIN);
			else
				pressure <= p_trunc[bsac_pkg::PRESS_W-1:0];
			if (temp_sum_q > bsac_pkg::T_MAX)
				temperature <= bsac_pkg::TEMP_W'(bsac_pkg::T_MAX);
			else if (temp_sum_q < bsac_pkg::T_MIN)
				temperature <= bsac_pkg::TEMP_W'(bsac_pkg::T_MIN);
			else
				temperature <= temp_sum_q[bsac_pkg::TEMP_W-1:0];
			in_range <= (x_q >= 42'(bsac_pkg::IN_RANGE_MIN));
		end
	end

endmodule

`default_nettype wire

// ===== rtl/bsac_ctrl.sv =====
// ----------------------------------------------------------------------------
// bsac_ctrl
// Sequencer for the compensation steps and the channel handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module bsac_ctrl (
	input  logic            clk,
	input  logic            arst_n,
	input  logic            in_valid,
	input  logic            in_cmd,
	output logic            in_ready,
	output logic            out_valid,
	input  logic            out_ready,
	output bsac_pkg::cmd_t  cmd
);

	bsac_pkg::state_t state_q, state_d;
	logic             out_valid_q;
	logic             in_xfer, out_free;

	assign in_ready  = (state_q == bsac_pkg::ST_IDLE);
	assign in_xfer   = in_valid && in_ready;
	assign out_free  = !out_valid_q || out_ready;
	assign out_valid = out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= bsac_pkg::ST_IDLE;
		else
			state_q <= state_d;
	end

	// next state and step commands
	always_comb begin
		state_d     = state_q;
		cmd         = '0;
		cmd.mul_sel = bsac_pkg::MUL_NONE;
		unique case (state_q)
			bsac_pkg::ST_IDLE: begin
				cmd.avg_upd = in_xfer;
				if (in_xfer && in_cmd == bsac_pkg::CMD_PRESS)
					state_d = bsac_pkg::ST_DT;
			end
			bsac_pkg::ST_DT: begin
				cmd.dt_ld = 1'b1;
				state_d   = bsac_pkg::ST_MUL_T;
			end
			bsac_pkg::ST_MUL_T: begin
				cmd.mul_sel = bsac_pkg::MUL_TEMP;
				state_d     = bsac_pkg::ST_MUL_OFF;
			end
			bsac_pkg::ST_MUL_OFF: begin
				cmd.mul_sel = bsac_pkg::MUL_OFF;
				cmd.temp_ld = 1'b1;
				state_d     = bsac_pkg::ST_MUL_SENS;
			end
			bsac_pkg::ST_MUL_SENS: begin
				cmd.mul_sel = bsac_pkg::MUL_SENS;
				cmd.off_ld  = 1'b1;
				state_d     = bsac_pkg::ST_SENS;
			end
			bsac_pkg::ST_SENS: begin
				cmd.sens_ld = 1'b1;
				state_d     = bsac_pkg::ST_MUL_LO;
			end
			bsac_pkg::ST_MUL_LO: begin
				cmd.mul_sel = bsac_pkg::MUL_LO;
				state_d     = bsac_pkg::ST_MUL_HI;
			end
			bsac_pkg::ST_MUL_HI: begin
				cmd.mul_sel = bsac_pkg::MUL_HI;
				cmd.acc_ld  = 1'b1;
				state_d     = bsac_pkg::ST_ACC;
			end
			bsac_pkg::ST_ACC: begin
				cmd.acc_add = 1'b1;
				state_d     = bsac_pkg::ST_X;
			end
			bsac_pkg::ST_X: begin
				cmd.x_ld = 1'b1;
				state_d  = bsac_pkg::ST_OUT;
			end
			bsac_pkg::ST_OUT: begin
				// wait for the result register to be free
				if (out_free) begin
					cmd.out_ld = 1'b1;
					state_d    = bsac_pkg::ST_IDLE;
				end
			end
			default: state_d = bsac_pkg::ST_IDLE;
		endcase
	end

	// result valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (cmd.out_ld)
			out_valid_q <= 1'b1;
		else if (out_ready)
			out_valid_q <= 1'b0;
	end

`ifndef ASSERT_OFF
	// a waiting result is never overwritten
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_ld |-> (!out_valid_q || out_ready))
		else $error("result register loaded while still held");

	// a pressure transfer starts the compensation sequence
	a_press_starts: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_cmd == bsac_pkg::CMD_PRESS) |=> state_q == bsac_pkg::ST_DT)
		else $error("pressure sample did not start compensation");

	// a temperature transfer gives no result and leaves the block ready
	a_temp_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_xfer && in_cmd == bsac_pkg::CMD_TEMP) |=> (in_ready && !cmd.out_ld))
		else $error("temperature sample left the controller busy");

	// the high partial product is always added right after the low one is loaded
	a_acc_order: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.acc_add |-> $past(cmd.acc_ld))
		else $error("accumulate without a preceding load");

	// averages move only on an input transfer
	a_avg_on_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.avg_upd |-> (in_valid && in_ready))
		else $error("average updated without a transfer");
`endif

endmodule

`default_nettype wire

// ===== rtl/baro_sample_average_compensate.sv =====
// ----------------------------------------------------------------------------
// baro_sample_average_compensate
// Running averages of raw temperature and pressure samples with first-order
// calibration of each pressure sample into temperature and pressure.
// ----------------------------------------------------------------------------
//  channel  dir  handshake      payload
//  in_ch    in   valid/ready    cmd (1), sample (24)
//  out_ch   out  valid/ready    pressure (s23), temperature (s19), in_range (1)
//  cfg      in   cfg_we         cfg_idx (3), cfg_wdata (16)
//
//  A temperature sample updates its average, gives no result and leaves
//  the block ready. A pressure sample steps through the states DT, MUL_T,
//  MUL_OFF, MUL_SENS, SENS, MUL_LO, MUL_HI, ACC, X and OUT, with five passes
//  through the single shared 25x19 multiplier plus the wide adds around it;
//  its result is loaded in OUT and the block then takes samples in IDLE.
//  Reset clears the coefficients, both averages and the controller. While
//  the output register holds an untaken result the next sample is still
//  taken; a second pressure result waits in its last step for it.
// ----------------------------------------------------------------------------
`default_nettype none

module baro_sample_average_compensate #(
	parameter int AVG_SHIFT = bsac_pkg::AVG_SHIFT_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	bsac_in_if.sink                          in_ch,
	bsac_out_if.source                       out_ch,
	input  logic                             cfg_we,
	input  logic [bsac_pkg::CFG_IDX_W-1:0]   cfg_idx,
	input  logic [bsac_pkg::COEF_W-1:0]      cfg_wdata
);

	bsac_pkg::cmd_t cmd;

	// sequencer
	bsac_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_ch.valid),
		.in_cmd    (in_ch.cmd),
		.in_ready  (in_ch.ready),
		.out_valid (out_ch.valid),
		.out_ready (out_ch.ready),
		.cmd       (cmd)
	);

	// arithmetic
	bsac_datapath #(
		.AVG_SHIFT (AVG_SHIFT)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.in_cmd      (in_ch.cmd),
		.in_sample   (in_ch.sample),
		.cfg_we      (cfg_we),
		.cfg_idx     (cfg_idx),
		.cfg_wdata   (cfg_wdata),
		.pressure    (out_ch.pressure),
		.temperature (out_ch.temperature),
		.in_range    (out_ch.in_range)
	);

endmodule

`default_nettype wire

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for baro_sample_average_compensate. Raw temperature
// and pressure samples are streamed through the block over several sets of
// calibration coefficients, with random idling on both channels. Every
// compensated result is compared field by field with an in-bench model of
// the running averages and the first-order calibration.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_top;

	localparam int RESET_CYCLES   = 9;
	localparam int SETTLE_CYCLES  = 32;
	localparam int WATCHDOG_LIMIT = 2000;
	localparam int LONG_HOLD      = 160;
	localparam int MAX_REPORTS    = 10;
	localparam int RANDOM_PHASES  = 6;

	// indexes past the coefficient list; writes there must be dropped
	localparam logic [bsac_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_LO = 3'd6;
	localparam logic [bsac_pkg::CFG_IDX_W-1:0] CFG_IDX_SPARE_HI = 3'd7;

	typedef struct {
		logic                          cmd;
		logic [bsac_pkg::SAMPLE_W-1:0] sample;
	} raw_sample_t;

	typedef struct {
		logic signed [bsac_pkg::PRESS_W-1:0] pressure;
		logic signed [bsac_pkg::TEMP_W-1:0]  temperature;
		logic                                in_range;
	} comp_result_t;

	logic                           clk;
	logic                           arst_n;
	logic                           cfg_we;
	logic [bsac_pkg::CFG_IDX_W-1:0] cfg_idx;
	logic [bsac_pkg::COEF_W-1:0]    cfg_wdata;

	bsac_in_if  in_ch ();
	bsac_out_if out_ch ();

	baro_sample_average_compensate dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_ch     (in_ch),
		.out_ch    (out_ch),
		.cfg_we    (cfg_we),
		.cfg_idx   (cfg_idx),
		.cfg_wdata (cfg_wdata)
	);

	// model state
	logic [bsac_pkg::COEF_W-1:0]   coef_m [bsac_pkg::NUM_COEF];
	logic [bsac_pkg::COEF_W-1:0]   coef_plan [bsac_pkg::NUM_COEF];
	logic [bsac_pkg::SAMPLE_W-1:0] avg_temp_m;
	logic [bsac_pkg::SAMPLE_W-1:0] avg_press_m;

	raw_sample_t  raw_sample_q [$];
	comp_result_t compensated_q [$];
	raw_sample_t  in_flight;
	comp_result_t oldest_result;

	int  n_queued, n_taken, n_press_taken;
	int  n_results, n_in_range, n_errors, n_reports, n_coef_sets;
	int  send_gap, stall_left, hold_len, quiet_cycles;
	logic calm;

	// clock
	always begin
		clk = 1'b0;
		#6;
		clk = 1'b1;
		#6;
	end

	// running average: empty average loads the sample, else moves by diff / 16
	function automatic logic [bsac_pkg::SAMPLE_W-1:0] track_average(
		input logic [bsac_pkg::SAMPLE_W-1:0] avg,
		input logic [bsac_pkg::SAMPLE_W-1:0] s);
		longint step;
		if (avg == '0)
			return s;
		step = (longint'(s) - longint'(avg)) / (longint'(1) << bsac_pkg::AVG_SHIFT_DEF);
		return bsac_pkg::SAMPLE_W'(longint'(avg) + step);
	endfunction

	// averaging plus first-order calibration; queues the result of a pressure sample
	function automatic void compensate_sample(input raw_sample_t it);
		longint dt, temp, off, sens, x, pres;
		comp_result_t r;
		if (it.cmd == bsac_pkg::CMD_TEMP) begin
			avg_temp_m = track_average(avg_temp_m, it.sample);
			return;
		end
		avg_press_m = track_average(avg_press_m, it.sample);
		n_press_taken++;

		dt   = longint'(avg_temp_m) - longint'(coef_m[bsac_pkg::REG_REF_TEMP]) * 256;
		temp = ((dt * longint'(coef_m[bsac_pkg::REG_TEMP_SENS])) >>> 23)
			+ bsac_pkg::T_OFFSET;
		off  = longint'(coef_m[bsac_pkg::REG_OFFSET]) * 131072
			+ (longint'(coef_m[bsac_pkg::REG_OFF_TEMPCO]) * dt) / 64;
		sens = longint'(coef_m[bsac_pkg::REG_SENS]) * 65536
			+ (longint'(coef_m[bsac_pkg::REG_SENS_TEMPCO]) * dt) / 128;
		x    = (longint'(avg_press_m) * sens) / 2097152 - off;
		pres = x / 32768;

		if (pres > bsac_pkg::P_MAX)
			pres = bsac_pkg::P_MAX;
		else if (pres < bsac_pkg::P_MIN)
			pres = bsac_pkg::P_MIN;
		if (temp > bsac_pkg::T_MAX)
			temp = bsac_pkg::T_MAX;
		else if (temp < bsac_pkg::T_MIN)
			temp = bsac_pkg::T_MIN;

		r.pressure    = bsac_pkg::PRESS_W'(pres);
		r.temperature = bsac_pkg::TEMP_W'(temp);
		r.in_range    = (x >= bsac_pkg::IN_RANGE_MIN);
		compensated_q.push_back(r);
	endfunction

	// sender: one transfer per handshake, random gap bursts between items
	always @(posedge clk) begin
		if (!arst_n) begin
			in_ch.valid <= 1'b0;
		end else begin
			if (in_ch.valid && in_ch.ready) begin
				compensate_sample(in_flight);
				n_taken++;
			end
			if (!in_ch.valid || in_ch.ready) begin
				if (send_gap > 0) begin
					send_gap--;
					in_ch.valid <= 1'b0;
				end else if (raw_sample_q.size() > 0) begin
					in_flight = raw_sample_q.pop_front();
					in_ch.valid  <= 1'b1;
					in_ch.cmd    <= in_flight.cmd;
					in_ch.sample <= in_flight.sample;
					if (!calm && $urandom_range(0, 9) == 0)
						send_gap = $urandom_range(1, 17);
				end else begin
					in_ch.valid <= 1'b0;
				end
			end
		end
	end

	// receiver: checks each result transfer, stalls in bursts or on a long hold
	always @(posedge clk) begin
		if (!arst_n) begin
			out_ch.ready <= 1'b0;
		end else begin
			if (out_ch.valid && out_ch.ready) begin
				n_results++;
				if (compensated_q.size() == 0) begin
					n_errors++;
					if (n_reports < MAX_REPORTS) begin
						n_reports++;
						$display("tb_top: unexpected result p=%0d t=%0d r=%0b",
							out_ch.pressure, out_ch.temperature, out_ch.in_range);
					end
				end else begin
					oldest_result = compensated_q.pop_front();
					if (out_ch.in_range)
						n_in_range++;
					if (out_ch.pressure !== oldest_result.pressure
						|| out_ch.temperature !== oldest_result.temperature
						|| out_ch.in_range !== oldest_result.in_range) begin
						n_errors++;
						if (n_reports < MAX_REPORTS) begin
							n_reports++;
							$display("tb_top: result %0d exp p=%0d t=%0d r=%0b",
								n_results, oldest_result.pressure,
								oldest_result.temperature, oldest_result.in_range);
							$display("tb_top:   got p=%0d t=%0d r=%0b",
								out_ch.pressure, out_ch.temperature, out_ch.in_range);
						end
					end
				end
			end
			if (hold_len > 0) begin
				hold_len--;
				out_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ch.ready <= 1'b0;
			end else begin
				out_ch.ready <= 1'b1;
				if (!calm && $urandom_range(0, 7) == 0)
					stall_left = $urandom_range(1, 17);
			end
		end
	end

	// watchdog on cycles without any transfer
	always @(posedge clk) begin
		if (!arst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
			quiet_cycles <= 0;
		end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("tb_top: no transfer for %0d cycles, %0d results outstanding",
				quiet_cycles, compensated_q.size());
			$display("tb_top: done, errors");
			$finish;
		end else begin
			quiet_cycles <= quiet_cycles + 1;
		end
	end

	function automatic void queue_sample(input logic kind,
		input logic [bsac_pkg::SAMPLE_W-1:0] s);
		raw_sample_t it;
		it.cmd    = kind;
		it.sample = s;
		raw_sample_q.push_back(it);
		n_queued++;
	endfunction

	// mostly plausible conversions, with zeros, full scale and raw noise mixed in
	function automatic logic [bsac_pkg::SAMPLE_W-1:0] pick_sample(input logic kind);
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3, 4: return bsac_pkg::SAMPLE_W'($urandom);
			default: begin
				if (kind == bsac_pkg::CMD_TEMP)
					return bsac_pkg::SAMPLE_W'($urandom_range(7000000, 9000000));
				return bsac_pkg::SAMPLE_W'($urandom_range(6000000, 10000000));
			end
		endcase
	endfunction

	// temperature followed by a few pressures, with lone samples as noise
	function automatic void queue_random(input int count);
		int  k, n_press;
		logic kind;
		k = 0;
		while (k < count) begin
			if ($urandom_range(0, 4) == 0) begin
				kind = ($urandom_range(0, 1) != 0) ? bsac_pkg::CMD_PRESS : bsac_pkg::CMD_TEMP;
				queue_sample(kind, pick_sample(kind));
				k++;
			end else begin
				queue_sample(bsac_pkg::CMD_TEMP, pick_sample(bsac_pkg::CMD_TEMP));
				n_press = $urandom_range(1, 3);
				repeat (n_press)
					queue_sample(bsac_pkg::CMD_PRESS, pick_sample(bsac_pkg::CMD_PRESS));
				k += 1 + n_press;
			end
		end
	endfunction

	// all queued samples taken, all results out, then let the block settle
	task automatic wait_idle();
		while (n_taken != n_queued || compensated_q.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// write the planned coefficients plus one write past the list
	task automatic program_coefs();
		int i;
		for (i = 0; i < bsac_pkg::NUM_COEF; i++) begin
			@(posedge clk);
			cfg_we    <= 1'b1;
			cfg_idx   <= bsac_pkg::CFG_IDX_W'(i);
			cfg_wdata <= coef_plan[i];
			coef_m[i] = coef_plan[i];
		end
		@(posedge clk);
		cfg_idx   <= ($urandom_range(0, 1) != 0) ? CFG_IDX_SPARE_HI : CFG_IDX_SPARE_LO;
		cfg_wdata <= bsac_pkg::COEF_W'($urandom);
		@(posedge clk);
		cfg_we <= 1'b0;
		n_coef_sets++;
	endtask

	// stimulus
	initial begin
		int phase, i;

		arst_n       = 1'b0;
		cfg_we       = 1'b0;
		cfg_idx      = '0;
		cfg_wdata    = '0;
		in_ch.valid  = 1'b0;
		in_ch.cmd    = bsac_pkg::CMD_TEMP;
		in_ch.sample = '0;
		out_ch.ready = 1'b0;
		calm         = 1'b0;
		send_gap     = 0;
		stall_left   = 0;
		hold_len     = 0;
		n_queued     = 0;
		n_taken      = 0;
		n_press_taken = 0;
		n_results    = 0;
		n_in_range   = 0;
		n_errors     = 0;
		n_reports    = 0;
		n_coef_sets  = 0;
		avg_temp_m   = '0;
		avg_press_m  = '0;
		for (i = 0; i < bsac_pkg::NUM_COEF; i++)
			coef_m[i] = '0;

		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// coefficients at reset: zero pressure on empty averages, before any temperature
		queue_sample(bsac_pkg::CMD_PRESS, '0);
		queue_sample(bsac_pkg::CMD_TEMP, '0);
		queue_sample(bsac_pkg::CMD_PRESS, '1);
		queue_sample(bsac_pkg::CMD_PRESS, '0);
		wait_idle();

		// typical calibration set
		coef_plan[bsac_pkg::REG_SENS]        = 16'd40127;
		coef_plan[bsac_pkg::REG_OFFSET]      = 16'd36924;
		coef_plan[bsac_pkg::REG_SENS_TEMPCO] = 16'd23317;
		coef_plan[bsac_pkg::REG_OFF_TEMPCO]  = 16'd23282;
		coef_plan[bsac_pkg::REG_REF_TEMP]    = 16'd33464;
		coef_plan[bsac_pkg::REG_TEMP_SENS]   = 16'd28312;
		program_coefs();
		queue_sample(bsac_pkg::CMD_TEMP, 24'd8077636);
		queue_sample(bsac_pkg::CMD_PRESS, 24'd9085466);
		queue_sample(bsac_pkg::CMD_PRESS, 24'd9085466);
		queue_sample(bsac_pkg::CMD_TEMP, '1);
		queue_sample(bsac_pkg::CMD_PRESS, 24'd1);
		queue_sample(bsac_pkg::CMD_TEMP, 24'd1);
		queue_sample(bsac_pkg::CMD_PRESS, '1);
		queue_sample(bsac_pkg::CMD_TEMP, 24'h800000);
		queue_sample(bsac_pkg::CMD_PRESS, 24'h7FFFFF);
		wait_idle();

		// every coefficient at full scale
		for (i = 0; i < bsac_pkg::NUM_COEF; i++)
			coef_plan[i] = '1;
		program_coefs();
		queue_sample(bsac_pkg::CMD_PRESS, '1);
		queue_sample(bsac_pkg::CMD_TEMP, '0);
		queue_sample(bsac_pkg::CMD_PRESS, '0);
		queue_sample(bsac_pkg::CMD_TEMP, '1);
		queue_sample(bsac_pkg::CMD_PRESS, 24'hAAAAAA);
		queue_sample(bsac_pkg::CMD_TEMP, 24'h555555);
		wait_idle();

		// large reference temperature: strongly negative dT, no base terms
		coef_plan[bsac_pkg::REG_SENS]   = '0;
		coef_plan[bsac_pkg::REG_OFFSET] = '0;
		program_coefs();
		queue_sample(bsac_pkg::CMD_PRESS, '1);
		queue_sample(bsac_pkg::CMD_PRESS, '0);
		wait_idle();

		// random phases, one coefficient set each
		for (phase = 0; phase < RANDOM_PHASES; phase++) begin
			for (i = 0; i < bsac_pkg::NUM_COEF; i++) begin
				if (phase == 1)
					coef_plan[i] = '1;
				else if (phase == 4)
					coef_plan[i] = ($urandom_range(0, 1) != 0) ? '1 : '0;
				else
					coef_plan[i] = bsac_pkg::COEF_W'($urandom);
			end
			if (phase == RANDOM_PHASES - 1)
				calm = 1'b1;
			program_coefs();
			queue_random(50);
			if (phase == 2) begin
				// long receiver hold-off while pressure samples keep coming
				@(negedge clk);
				hold_len = LONG_HOLD;
				repeat (30)
					queue_sample(bsac_pkg::CMD_PRESS, pick_sample(bsac_pkg::CMD_PRESS));
			end
			if (phase == 3)
				wait_idle();
			queue_random(45);
			wait_idle();
		end

		$display("tb_top: %0d samples sent (%0d pressure) over %0d coefficient sets",
			n_taken, n_press_taken, n_coef_sets);
		$display("tb_top: %0d results checked, %0d in range, %0d mismatches",
			n_results, n_in_range, n_errors);
		if (n_errors == 0 && compensated_q.size() == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

`default_nettype wire
